FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the chunked body decoder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: rtl/core/hbcd_pkg.sv
// Types, codes and constants of the chunked body decoder
package hbcd_pkg;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_T  = 8'h54;

	// length of "Transfer-Encoding: chunked"
	localparam logic [4:0] PAT_LEN = 5'd26;

	localparam logic [2:0] TERM_DONE = 3'd4;
	localparam logic [2:0] OFFSET_MAX = 3'd7;
	localparam logic [2:0] OFFSET_AT_START = 3'd4;
	localparam logic [1:0] SKIP_BYTES = 2'd2;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_PLAIN,
		PH_SIZE,
		PH_DATA,
		PH_SKIP,
		PH_DONE,
		PH_DISCARD
	} phase_t;

	typedef enum logic [1:0] {
		OC_PLAIN,
		OC_CHUNKED,
		OC_NO_HDR_END,
		OC_OVERFLOW
	} outcome_t;

	typedef struct packed {
		logic [7:0] resp_byte;
		logic       resp_last;
	} resp_t;

	typedef struct packed {
		logic [7:0] body_byte;
		logic       body_valid;
		logic       body_end;
		outcome_t   outcome;
	} body_t;

	// byte after classification by the front
	typedef struct packed {
		logic [7:0] byte_val;
		logic       last;
		logic       hex_ok;
		logic [3:0] hex_val;
		logic       is_cr;
		logic       is_lf;
	} cls_t;

	function automatic logic [7:0] te_char(input logic [4:0] idx);
		logic [7:0] ch;
		case (idx)
			5'd0:    ch = "T";
			5'd1:    ch = "r";
			5'd2:    ch = "a";
			5'd3:    ch = "n";
			5'd4:    ch = "s";
			5'd5:    ch = "f";
			5'd6:    ch = "e";
			5'd7:    ch = "r";
			5'd8:    ch = "-";
			5'd9:    ch = "E";
			5'd10:   ch = "n";
			5'd11:   ch = "c";
			5'd12:   ch = "o";
			5'd13:   ch = "d";
			5'd14:   ch = "i";
			5'd15:   ch = "n";
			5'd16:   ch = "g";
			5'd17:   ch = ":";
			5'd18:   ch = " ";
			5'd19:   ch = "c";
			5'd20:   ch = "h";
			5'd21:   ch = "u";
			5'd22:   ch = "n";
			5'd23:   ch = "k";
			5'd24:   ch = "e";
			5'd25:   ch = "d";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

FILE: rtl/core/hbcd_fifo.sv
// Small register queue used between the decoder parts and at the result side
`include "assert_macros.svh"

module hbcd_fifo #(
	parameter int DATA_W     = 8,
	parameter int DEPTH_LOG2 = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] din,
	output logic              full,
	input  logic              pop,
	output logic [DATA_W-1:0] dout,
	output logic              empty
);

	localparam int DEPTH = 1 << DEPTH_LOG2;

	logic [DATA_W-1:0]   mem_q [DEPTH];
	logic [DEPTH_LOG2-1:0] wr_q;
	logic [DEPTH_LOG2-1:0] rd_q;
	logic [DEPTH_LOG2:0]   cnt_q;
	logic                  do_push;
	logic                  do_pop;

	assign full    = (cnt_q == (DEPTH_LOG2+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`ASSERT_NXT(a_push_fills, clk, arst_n, do_push && !do_pop, !empty, "queue empty after push")
	`ASSERT_NXT(a_pop_drains, clk, arst_n, do_pop && !do_push && cnt_q == 1, empty, "queue not drained")
	`ASSERT_IMP(a_full_empty, clk, arst_n, 1'b1, !(full && empty), "queue full and empty")

endmodule

FILE: rtl/core/hbcd_front.sv
// Front of the decoder: takes response bytes and classifies them
module hbcd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hbcd_pkg::resp_t resp,
	output logic          full,
	output logic          q_push,
	output hbcd_pkg::cls_t q_item,
	input  logic          q_full
);

	logic           valid_s1;
	hbcd_pkg::cls_t item_s1;
	hbcd_pkg::cls_t cls;
	logic           take;
	logic [7:0]     c;

	assign full   = valid_s1 && q_full;
	assign take   = push && !full;
	assign q_push = valid_s1;
	assign q_item = item_s1;
	assign c      = resp.resp_byte;

	always_comb begin
		cls.byte_val = c;
		cls.last     = resp.resp_last;
		cls.is_cr    = (c == hbcd_pkg::CH_CR);
		cls.is_lf    = (c == hbcd_pkg::CH_LF);
		cls.hex_ok   = 1'b1;
		cls.hex_val  = 4'd0;
		if (c >= "0" && c <= "9") begin
			cls.hex_val = c[3:0];
		end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
			// letters a..f differ from A..F only in bit 5
			cls.hex_val = c[3:0] + 4'd9;
		end else begin
			cls.hex_ok = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (!q_full) begin
			valid_s1 <= 1'b0;
		end
	end

endmodule

FILE: rtl/core/hbcd_back.sv
// Back of the decoder: header scan, chunk size parsing and body emission
`include "assert_macros.svh"

module hbcd_back #(
	parameter int SIZE_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  hbcd_pkg::cls_t item,
	output logic           q_pop,
	output logic           out_push,
	output hbcd_pkg::body_t res,
	input  logic           out_full
);

	hbcd_pkg::phase_t     phase_q, phase_d;
	logic [2:0]           term_q, term_d;
	logic [2:0]           off_q, off_d;
	logic [4:0]           pat_q, pat_d;
	logic                 chunked_q, chunked_d;
	logic [SIZE_BITS-1:0] acc_q, acc_d;
	logic [1:0]           stat_q, stat_d;
	logic [SIZE_BITS-1:0] rem_q, rem_d;
	logic [1:0]           skip_q, skip_d;
	logic                 ovf_q, ovf_d;

	logic                 go;
	logic                 emit;
	logic                 tail;
	logic [SIZE_BITS-1:0] rem_dec;
	logic [1:0]           skip_dec;
	logic [7:0]           c;
	hbcd_pkg::outcome_t   oc;

	assign go    = !q_empty && !out_full;
	assign q_pop = go;
	assign c     = item.byte_val;

	always_comb begin
		phase_d   = phase_q;
		term_d    = term_q;
		off_d     = off_q;
		pat_d     = pat_q;
		chunked_d = chunked_q;
		acc_d     = acc_q;
		stat_d    = stat_q;
		rem_d     = rem_q;
		skip_d    = skip_q;
		ovf_d     = ovf_q;
		emit      = 1'b0;
		tail      = stat_q[0];
		rem_dec   = (rem_q != '0) ? rem_q - 1'b1 : rem_q;
		skip_dec  = (skip_q != '0) ? skip_q - 1'b1 : skip_q;
		oc        = hbcd_pkg::OC_PLAIN;

		if (go) begin
			case (phase_q)
				hbcd_pkg::PH_HEADER: begin
					if (off_q < hbcd_pkg::OFFSET_MAX) begin
						off_d = off_q + 1'b1;
					end
					if (pat_q < hbcd_pkg::PAT_LEN) begin
						if (c == hbcd_pkg::te_char(pat_q)) begin
							pat_d = pat_q + 1'b1;
						end else begin
							pat_d = (c == hbcd_pkg::CH_T) ? 5'd1 : 5'd0;
						end
						if (pat_d == hbcd_pkg::PAT_LEN) begin
							chunked_d = 1'b1;
						end
					end
					// CR LF CR LF tracker
					if ((term_q == 3'd1 || term_q == 3'd3) && item.is_lf) begin
						term_d = term_q + 1'b1;
					end else if (term_q == 3'd2 && item.is_cr) begin
						term_d = 3'd3;
					end else begin
						term_d = item.is_cr ? 3'd1 : 3'd0;
					end
					if (term_d == hbcd_pkg::TERM_DONE) begin
						term_d = '0;
						if (off_d == hbcd_pkg::OFFSET_AT_START) begin
							phase_d = hbcd_pkg::PH_DISCARD;
						end else begin
							phase_d = chunked_d ? hbcd_pkg::PH_SIZE : hbcd_pkg::PH_PLAIN;
						end
						acc_d  = '0;
						stat_d = '0;
					end
				end
				hbcd_pkg::PH_PLAIN: begin
					emit = 1'b1;
				end
				hbcd_pkg::PH_SIZE: begin
					if (stat_q[1] && item.is_lf) begin
						if (acc_q == '0) begin
							phase_d = hbcd_pkg::PH_DONE;
						end else begin
							rem_d   = acc_q;
							phase_d = hbcd_pkg::PH_DATA;
						end
						stat_d = '0;
					end else begin
						if (!stat_q[0] && item.hex_ok) begin
							if (acc_q[SIZE_BITS-1 -: 4] != 4'd0) begin
								acc_d = '1;
								ovf_d = 1'b1;
							end else begin
								acc_d = {acc_q[SIZE_BITS-5:0], item.hex_val};
							end
						end else begin
							tail = 1'b1;
						end
						stat_d = {item.is_cr, tail};
					end
				end
				hbcd_pkg::PH_DATA: begin
					emit  = 1'b1;
					rem_d = rem_dec;
					if (rem_dec == '0) begin
						phase_d = hbcd_pkg::PH_SKIP;
						skip_d  = hbcd_pkg::SKIP_BYTES;
					end
				end
				hbcd_pkg::PH_SKIP: begin
					skip_d = skip_dec;
					if (skip_dec == '0) begin
						phase_d = hbcd_pkg::PH_SIZE;
						acc_d   = '0;
						stat_d  = '0;
					end
				end
				default: begin
				end
			endcase

			if (item.last) begin
				if (ovf_d) begin
					oc = hbcd_pkg::OC_OVERFLOW;
				end else if (phase_d == hbcd_pkg::PH_HEADER ||
						phase_d == hbcd_pkg::PH_DISCARD) begin
					oc = hbcd_pkg::OC_NO_HDR_END;
				end else if (chunked_d) begin
					oc = hbcd_pkg::OC_CHUNKED;
				end else begin
					oc = hbcd_pkg::OC_PLAIN;
				end
				// next byte starts a fresh response
				phase_d   = hbcd_pkg::PH_HEADER;
				term_d    = '0;
				off_d     = '0;
				pat_d     = '0;
				chunked_d = 1'b0;
				acc_d     = '0;
				stat_d    = '0;
				rem_d     = '0;
				skip_d    = '0;
				ovf_d     = 1'b0;
			end
		end

		out_push       = go && (emit || item.last);
		res.body_byte  = emit ? c : 8'd0;
		res.body_valid = emit;
		res.body_end   = item.last;
		res.outcome    = oc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= hbcd_pkg::PH_HEADER;
			term_q    <= '0;
			off_q     <= '0;
			pat_q     <= '0;
			chunked_q <= 1'b0;
			acc_q     <= '0;
			stat_q    <= '0;
			rem_q     <= '0;
			skip_q    <= '0;
			ovf_q     <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			term_q    <= term_d;
			off_q     <= off_d;
			pat_q     <= pat_d;
			chunked_q <= chunked_d;
			acc_q     <= acc_d;
			stat_q    <= stat_d;
			rem_q     <= rem_d;
			skip_q    <= skip_d;
			ovf_q     <= ovf_d;
		end
	end

	`ASSERT_NXT(a_last_rearms, clk, arst_n, go && item.last, phase_q == hbcd_pkg::PH_HEADER, "no rearm after last byte")
	`ASSERT_IMP(a_data_nonzero, clk, arst_n, phase_q == hbcd_pkg::PH_DATA, rem_q != '0, "data phase with zero count")
	`ASSERT_IMP(a_outcome_on_end, clk, arst_n, out_push && !res.body_end, res.outcome == hbcd_pkg::OC_PLAIN, "outcome without end")

endmodule

FILE: rtl/core/http_body_chunk_decoder.sv
// Top level of the HTTP body decoder with chunked transfer decoding
//
//  channel   ports                  transaction
//  ------    --------------------   ---------------------------------
//  response  push, full, resp       push & !full, one byte per transaction
//  body      empty, pop, body       pop & !empty, zero or one per byte
//
// Sustains one response byte per cycle unless full; each byte is one parser pass.
// A byte's result passes the front register, middle queue, parser and result queue.
// Reset clears all parser state and both queues; no clearing pass is needed.
// A stalled body side fills the result queue, then the middle queue, then raises full.
// The last byte of a response returns the parser to its header scan.
module http_body_chunk_decoder #(
	parameter int SIZE_BITS    = 32,
	parameter int Q_DEPTH_LOG2 = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  hbcd_pkg::resp_t resp,
	output logic            full,
	output logic            empty,
	input  logic            pop,
	output hbcd_pkg::body_t body
);

	localparam int CLS_W  = $bits(hbcd_pkg::cls_t);
	localparam int BODY_W = $bits(hbcd_pkg::body_t);

	logic            mid_push;
	logic            mid_full;
	logic            mid_empty;
	logic            mid_pop;
	hbcd_pkg::cls_t  mid_in;
	logic [CLS_W-1:0] mid_out;
	hbcd_pkg::cls_t  mid_item;
	logic            res_push;
	logic            res_full;
	hbcd_pkg::body_t res_item;
	logic [BODY_W-1:0] res_out;

	assign mid_item = hbcd_pkg::cls_t'(mid_out);
	assign body     = hbcd_pkg::body_t'(res_out);

	hbcd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.resp   (resp),
		.full   (full),
		.q_push (mid_push),
		.q_item (mid_in),
		.q_full (mid_full)
	);

	hbcd_fifo #(
		.DATA_W     (CLS_W),
		.DEPTH_LOG2 (Q_DEPTH_LOG2)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.din    (mid_in),
		.full   (mid_full),
		.pop    (mid_pop),
		.dout   (mid_out),
		.empty  (mid_empty)
	);

	hbcd_back #(
		.SIZE_BITS (SIZE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (mid_empty),
		.item     (mid_item),
		.q_pop    (mid_pop),
		.out_push (res_push),
		.res      (res_item),
		.out_full (res_full)
	);

	hbcd_fifo #(
		.DATA_W     (BODY_W),
		.DEPTH_LOG2 (Q_DEPTH_LOG2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_item),
		.full   (res_full),
		.pop    (pop),
		.dout   (res_out),
		.empty  (empty)
	);

endmodule
